>>> rtl/spe_pkg.sv
package spe_pkg;

   typedef enum logic [1:0] {
      CMD_LOAD_VEC   = 2'd0,
      CMD_LOAD_MODE  = 2'd1,
      CMD_LOAD_STATE = 2'd2,
      CMD_EVAL       = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type            command;
      logic [5:0]         grid_index;
      logic [5:0]         mode_index;
      logic signed [31:0] value_re;
      logic signed [31:0] value_im;
      logic signed [31:0] energy;
      logic signed [31:0] time_req;
   } req_type;

   typedef struct packed {
      logic [63:0] theta;
      logic        was_relative;
      logic        saturated;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_K_RD,
      ST_K_EMUL,
      ST_M_GO,
      ST_M_WAIT,
      ST_CORD,
      ST_CX,
      ST_CXS,
      ST_PJ,
      ST_PJ_WAIT,
      ST_FIN,
      ST_ROOT,
      ST_OUT
   } state_type;

   // jobs run in this order on the shared 64x64 multiplier
   typedef enum logic [2:0] {
      JOB_PHASE,
      JOB_SC_RE,
      JOB_SC_IM,
      JOB_SQ_DRE,
      JOB_SQ_DIM,
      JOB_SQ_CRE,
      JOB_SQ_CIM
   } job_type;

   localparam logic [1:0] CSR_ACTIVE_SIZE   = 2'd0;
   localparam logic [1:0] CSR_GRID_SPACING  = 2'd1;
   localparam logic [1:0] CSR_RELATIVE_MODE = 2'd2;

   localparam logic [6:0]  ACTIVE_SIZE_RST  = 7'd64;
   localparam logic [31:0] GRID_SPACING_RST = 32'd65536;
   localparam logic [31:0] DX_ONE           = 32'd65536;

   localparam logic [63:0]        INV_TWO_PI_Q64 = 64'h28BE_60DB_9391_054A;
   localparam logic [32:0]        TWO_PI_Q30     = 33'd6746518852;
   localparam logic signed [33:0] GAIN_Q30       = 34'sd652032874;
   localparam logic signed [63:0] COMP_LIMIT     = 64'sh0400_0000_0000_0000;

   function automatic logic signed [33:0] atan_q30(input logic [4:0] idx);
      logic signed [33:0] r;
      case (idx)
         5'd0: r = 34'sd843314857;
         5'd1: r = 34'sd497837830;
         5'd2: r = 34'sd263043837;
         5'd3: r = 34'sd133525159;
         5'd4: r = 34'sd67021687;
         5'd5: r = 34'sd33543516;
         5'd6: r = 34'sd16775851;
         5'd7: r = 34'sd8388437;
         5'd8: r = 34'sd4194283;
         5'd9: r = 34'sd2097149;
         default: begin
            if (idx == 5'd31) r = '0;
            else r = 34'sd1 <<< (5'd30 - idx);
         end
      endcase
      return r;
   endfunction

endpackage

>>> rtl/spe_store.sv
module spe_store #(
   parameter int MAX_SIZE = 64
) (
   input  logic                                    clock,
   input  logic                                    load_valid,
   input  spe_pkg::req_type                        load_data,
   input  logic [$clog2(MAX_SIZE)-1:0]             mode_addr,
   input  logic [$clog2(MAX_SIZE)-1:0]             st_addr,
   input  logic [$clog2(MAX_SIZE*MAX_SIZE)-1:0]    vec_addr,
   output logic [63:0]                             vec_q,
   output logic [63:0]                             st_q,
   output logic [63:0]                             coeff_q,
   output logic [31:0]                             energy_q
);
   import spe_pkg::*;

   localparam int IW = $clog2(MAX_SIZE);
   localparam int AW = $clog2(MAX_SIZE*MAX_SIZE);

   logic [63:0] vec_mem    [MAX_SIZE*MAX_SIZE];
   logic [63:0] st_mem     [MAX_SIZE];
   logic [63:0] coeff_mem  [MAX_SIZE];
   logic [31:0] energy_mem [MAX_SIZE];

   logic          g_ok, k_ok;
   logic [IW-1:0] g_idx, k_idx;
   logic [AW-1:0] wr_vaddr;
   logic          wr_vec, wr_mode, wr_st;

   always_comb begin
      g_ok     = 32'(load_data.grid_index) < 32'(MAX_SIZE);
      k_ok     = 32'(load_data.mode_index) < 32'(MAX_SIZE);
      g_idx    = IW'(load_data.grid_index);
      k_idx    = IW'(load_data.mode_index);
      wr_vaddr = AW'(g_idx) * AW'(MAX_SIZE) + AW'(k_idx);
      wr_vec   = load_valid && load_data.command == CMD_LOAD_VEC && g_ok && k_ok;
      wr_mode  = load_valid && load_data.command == CMD_LOAD_MODE && k_ok;
      wr_st    = load_valid && load_data.command == CMD_LOAD_STATE && g_ok;
   end

   always_ff @(posedge clock) begin
      if (wr_vec) vec_mem[wr_vaddr] <= {load_data.value_re, load_data.value_im};
      vec_q <= vec_mem[vec_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_st) st_mem[g_idx] <= {load_data.value_re, load_data.value_im};
      st_q <= st_mem[st_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_mode) coeff_mem[k_idx] <= {load_data.value_re, load_data.value_im};
      coeff_q <= coeff_mem[mode_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_mode) energy_mem[k_idx] <= load_data.energy;
      energy_q <= energy_mem[mode_addr];
   end

endmodule

>>> rtl/spe_mul64.sv
module spe_mul64 (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [63:0]   op_a,
   input  logic [63:0]   op_b,
   output logic          done,
   output logic [127:0]  prod
);
   logic [63:0]  a_ff, b_ff;
   logic [2:0]   cnt_ff;
   logic         busy_ff, done_ff;
   logic [63:0]  pp_ff;
   logic [1:0]   sh_ff;
   logic [127:0] acc_ff;
   logic [31:0]  a_half, b_half;
   logic [127:0] pp_shift;

   // partial product order: lo*lo, lo*hi, hi*lo, hi*hi
   always_comb begin
      a_half = cnt_ff[1] ? a_ff[63:32] : a_ff[31:0];
      b_half = cnt_ff[0] ? b_ff[63:32] : b_ff[31:0];
      case (sh_ff)
         2'd0:    pp_shift = {64'd0, pp_ff};
         2'd1:    pp_shift = {32'd0, pp_ff, 32'd0};
         default: pp_shift = {pp_ff, 64'd0};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && cnt_ff == 3'd4;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 3'd1;
            if (cnt_ff == 3'd4) busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff <= op_a;
         b_ff <= op_b;
      end
      pp_ff <= 64'(a_half) * 64'(b_half);
      case (cnt_ff[1:0])
         2'd0:    sh_ff <= 2'd0;
         2'd3:    sh_ff <= 2'd2;
         default: sh_ff <= 2'd1;
      endcase
      if (start) acc_ff <= '0;
      else if (busy_ff && cnt_ff != 3'd0) acc_ff <= acc_ff + pp_shift;
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

>>> rtl/spe_cordic.sv
module spe_cordic #(
   parameter int CORDIC_STEPS = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [31:0]        turn,
   output logic               done,
   output logic signed [32:0] cos_out,
   output logic signed [32:0] sin_out
);
   import spe_pkg::*;

   localparam int SW = $clog2(CORDIC_STEPS);
   localparam logic [1:0] QUAD_I   = 2'd0;
   localparam logic [1:0] QUAD_II  = 2'd1;
   localparam logic [1:0] QUAD_III = 2'd2;

   logic               pre_ff, busy_ff, done_ff;
   logic [SW-1:0]      i_ff;
   logic [1:0]         q_ff;
   logic [62:0]        zm_ff;
   logic signed [33:0] x_ff, y_ff, z_ff;
   logic signed [33:0] ang, xs, ys;

   always_comb begin
      ang = atan_q30(5'(i_ff));
      xs  = x_ff >>> i_ff;
      ys  = y_ff >>> i_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_ff  <= 1'b0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         i_ff    <= '0;
      end else begin
         done_ff <= busy_ff && i_ff == SW'(CORDIC_STEPS - 1);
         if (start) begin
            pre_ff <= 1'b1;
         end else if (pre_ff) begin
            pre_ff  <= 1'b0;
            busy_ff <= 1'b1;
            i_ff    <= '0;
         end else if (busy_ff) begin
            i_ff <= i_ff + SW'(1);
            if (i_ff == SW'(CORDIC_STEPS - 1)) busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff  <= turn[31:30];
         zm_ff <= 63'(turn[29:0]) * 63'(TWO_PI_Q30);
      end else if (pre_ff) begin
         x_ff <= GAIN_Q30;
         y_ff <= '0;
         z_ff <= 34'(zm_ff[62:32]);
      end else if (busy_ff) begin
         if (!z_ff[33]) begin
            x_ff <= x_ff - ys;
            y_ff <= y_ff + xs;
            z_ff <= z_ff - ang;
         end else begin
            x_ff <= x_ff + ys;
            y_ff <= y_ff - xs;
            z_ff <= z_ff + ang;
         end
      end
   end

   always_comb begin
      case (q_ff)
         QUAD_I: begin
            cos_out = 33'(x_ff);
            sin_out = 33'(y_ff);
         end
         QUAD_II: begin
            cos_out = 33'(-y_ff);
            sin_out = 33'(x_ff);
         end
         QUAD_III: begin
            cos_out = 33'(-x_ff);
            sin_out = 33'(-y_ff);
         end
         default: begin
            cos_out = 33'(y_ff);
            sin_out = 33'(-x_ff);
         end
      endcase
   end

   assign done = done_ff;

endmodule

>>> rtl/spe_root.sv
module spe_root (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [127:0]  num,
   input  logic [127:0]  den,
   output logic          done,
   output logic [63:0]   root
);
   // floor(sqrt(num * 2^96 / den)): restoring divide, then digit-by-digit root
   localparam logic [7:0] DIV_LAST  = 8'd223;
   localparam logic [7:0] SQRT_LAST = 8'd63;

   logic         busy_ff, sq_ff, done_ff;
   logic [7:0]   cnt_ff;
   logic [127:0] sh_ff, den_ff, rem_ff, quo_ff;
   logic [66:0]  r2_ff;
   logic [63:0]  root_ff;
   logic [127:0] rem_sh;
   logic [66:0]  r2_sh, trial;
   logic         div_ge, sq_ge;

   always_comb begin
      rem_sh = {rem_ff[126:0], sh_ff[127]};
      div_ge = rem_sh >= den_ff;
      r2_sh  = {r2_ff[64:0], quo_ff[127:126]};
      trial  = {1'b0, root_ff, 2'b01};
      sq_ge  = r2_sh >= trial;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         sq_ff   <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && sq_ff && cnt_ff == SQRT_LAST;
         if (start) begin
            busy_ff <= 1'b1;
            sq_ff   <= 1'b0;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 8'd1;
            if (!sq_ff && cnt_ff == DIV_LAST) begin
               sq_ff  <= 1'b1;
               cnt_ff <= '0;
            end
            if (sq_ff && cnt_ff == SQRT_LAST) busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         sh_ff   <= num;
         den_ff  <= den;
         rem_ff  <= '0;
         quo_ff  <= '0;
         r2_ff   <= '0;
         root_ff <= '0;
      end else if (busy_ff && !sq_ff) begin
         sh_ff  <= {sh_ff[126:0], 1'b0};
         rem_ff <= div_ge ? rem_sh - den_ff : rem_sh;
         quo_ff <= {quo_ff[126:0], div_ge};
      end else if (busy_ff) begin
         quo_ff  <= {quo_ff[125:0], 2'b00};
         r2_ff   <= sq_ge ? r2_sh - trial : r2_sh;
         root_ff <= {root_ff[62:0], sq_ge};
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

>>> rtl/spectral_projection_error_unit.sv
// Spectral projection error unit.
// req channel (valid/ready) carries load and evaluate beats. Load beats write
// one element of the eigenvector matrix, the eigenvalue/coefficient tables or
// the state vector and are taken one per cycle while idle; they produce no rsp beat.
// An evaluate beat produces exactly one rsp beat with theta, was_relative and
// saturated. csr channel writes active_size, grid_spacing and relative_mode;
// csr_ready is always high and writes belong between evaluations.
// Evaluate time grows with the number of active modes, and relative mode can
// add a root at the end. Per mode the time is set by the projection walk (one
// matrix entry per cycle from the eigenvector RAM), the iterative CORDIC and
// seven passes through the shared 64x64 multiplier; the relative root adds a
// 224-step divider and a 64-step root.
// req_ready is low from the evaluate beat until its result is registered.
// The result register frees the datapath: if rsp_ready is low, req_ready
// stays high for loads and a new evaluate waits only when it finishes.
// Synchronous reset restores register defaults and idles the sequencer; the
// element RAMs are not cleared and hold garbage until loaded.
module spectral_projection_error_unit #(
   parameter int MAX_SIZE     = 64,
   parameter int CORDIC_STEPS = 24
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  spe_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output spe_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [31:0]      csr_wdata
);
   import spe_pkg::*;

   localparam int IW = $clog2(MAX_SIZE);
   localparam int AW = $clog2(MAX_SIZE*MAX_SIZE);
   localparam int CW = $clog2(MAX_SIZE+1);

   state_type state_ff, state_in;
   job_type   job_ff;

   logic [6:0]  active_ff;
   logic [31:0] spacing_ff;
   logic        relcfg_ff;

   logic [CW-1:0]      n_ff, k_ff, j_ff, n_eval;
   logic [AW-1:0]      vaddr_ff;
   logic [31:0]        dx_ff;
   logic signed [31:0] t_ff, c0r_ff, c0i_ff;
   logic               rel_ff;
   logic signed [63:0] a_ff, cre_ff, cim_ff, are_ff, aim_ff, dre_ff, dim_ff;
   logic signed [32:0] cos_ff, sin_ff;
   logic signed [64:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic               rdv_ff, prv_ff;
   logic [127:0]       num_ff, den_ff;
   logic [63:0]        res_theta_ff;
   logic               res_sat_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   logic               req_accept, load_valid, is_eval;
   logic               mul_start, mul_done, cordic_start, cordic_done;
   logic               root_start, root_done, rsp_load, sel_cx;
   logic [63:0]        mul_a, mul_b, root_q;
   logic [127:0]       mul_p, den_fix;
   logic               rel_sat;
   logic [31:0]        turn;
   logic signed [32:0] cos_q, sin_q;
   logic [63:0]        vec_q, st_q, coeff_q;
   logic [31:0]        energy_q;
   logic signed [31:0] op_ar, op_ai;
   logic signed [32:0] op_br, op_bi;
   logic signed [63:0] sc_val;

   function automatic logic [63:0] mag(input logic signed [63:0] v);
      return v[63] ? 64'(-v) : 64'(v);
   endfunction

   function automatic logic signed [63:0] scale_out(input logic [127:0] p, input logic neg);
      logic [63:0] m;
      m = (p[127:88] != '0 || p[87:24] > 64'(COMP_LIMIT)) ? 64'(COMP_LIMIT) : p[87:24];
      return neg ? -signed'(m) : signed'(m);
   endfunction

   function automatic logic signed [63:0] clamp(input logic signed [63:0] v);
      if (v > COMP_LIMIT) return COMP_LIMIT;
      if (v < -COMP_LIMIT) return -COMP_LIMIT;
      return v;
   endfunction

   function automatic logic [127:0] sat_add(input logic [127:0] a, input logic [127:0] b);
      logic [128:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[128] ? '1 : s[127:0];
   endfunction

   spe_store #(.MAX_SIZE(MAX_SIZE)) u_store (
      .clock      (clock),
      .load_valid (load_valid),
      .load_data  (req_data),
      .mode_addr  (k_ff[IW-1:0]),
      .st_addr    (j_ff[IW-1:0]),
      .vec_addr   (vaddr_ff),
      .vec_q      (vec_q),
      .st_q       (st_q),
      .coeff_q    (coeff_q),
      .energy_q   (energy_q)
   );

   spe_mul64 u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .done  (mul_done),
      .prod  (mul_p)
   );

   spe_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cordic_start),
      .turn    (turn),
      .done    (cordic_done),
      .cos_out (cos_q),
      .sin_out (sin_q)
   );

   spe_root u_root (
      .clock (clock),
      .reset (reset),
      .start (root_start),
      .num   (num_ff),
      .den   (den_fix),
      .done  (root_done),
      .root  (root_q)
   );

   // datapath helpers
   always_comb begin
      is_eval = req_data.command == CMD_EVAL;
      if (32'(active_ff) >= 32'(MAX_SIZE)) n_eval = CW'(MAX_SIZE);
      else n_eval = CW'(active_ff);
      turn = a_ff[63] ? 32'd0 - mul_p[95:64] : mul_p[95:64];
      den_fix = (den_ff == '0) ? 128'd1 : den_ff;
      rel_sat = den_fix[127:96] != '0 || num_ff >= (den_fix << 32);
      sel_cx = state_ff == ST_CX;
      op_ar = sel_cx ? c0r_ff : signed'(vec_q[63:32]);
      op_ai = sel_cx ? c0i_ff : signed'(vec_q[31:0]);
      op_br = sel_cx ? cos_ff : signed'({st_q[63], st_q[63:32]});
      op_bi = sel_cx ? sin_ff : signed'({st_q[31], st_q[31:0]});
      sc_val = scale_out(mul_p, job_ff == JOB_SC_RE ? are_ff[63] : aim_ff[63]);
      case (job_ff)
         JOB_PHASE: begin
            mul_a = mag(a_ff);
            mul_b = INV_TWO_PI_Q64;
         end
         JOB_SC_RE: begin
            mul_a = mag(are_ff);
            mul_b = {32'd0, dx_ff};
         end
         JOB_SC_IM: begin
            mul_a = mag(aim_ff);
            mul_b = {32'd0, dx_ff};
         end
         JOB_SQ_DRE: begin
            mul_a = mag(dre_ff);
            mul_b = mag(dre_ff);
         end
         JOB_SQ_DIM: begin
            mul_a = mag(dim_ff);
            mul_b = mag(dim_ff);
         end
         JOB_SQ_CRE: begin
            mul_a = mag(cre_ff);
            mul_b = mag(cre_ff);
         end
         JOB_SQ_CIM: begin
            mul_a = mag(cim_ff);
            mul_b = mag(cim_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready    = state_ff == ST_IDLE;
      req_accept   = req_valid && req_ready;
      load_valid   = req_accept && !is_eval;
      mul_start    = state_ff == ST_M_GO;
      cordic_start = state_ff == ST_M_WAIT && mul_done && job_ff == JOB_PHASE;
      root_start   = state_ff == ST_FIN && rel_ff && !rel_sat;
      rsp_load     = state_ff == ST_OUT && (!rsp_valid_ff || rsp_ready);
      csr_ready    = 1'b1;
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:
            if (req_accept && is_eval) state_in = (n_eval == '0) ? ST_FIN : ST_K_RD;
         ST_K_RD:   state_in = ST_K_EMUL;
         ST_K_EMUL: state_in = ST_M_GO;
         ST_M_GO:   state_in = ST_M_WAIT;
         ST_M_WAIT: begin
            if (mul_done) begin
               case (job_ff)
                  JOB_PHASE:  state_in = ST_CORD;
                  JOB_SQ_CIM: state_in = (k_ff + CW'(1) == n_ff) ? ST_FIN : ST_K_RD;
                  default:    state_in = ST_M_GO;
               endcase
            end
         end
         ST_CORD:    if (cordic_done) state_in = ST_CX;
         ST_CX:      state_in = ST_CXS;
         ST_CXS:     state_in = ST_PJ;
         ST_PJ:      if (j_ff == n_ff - CW'(1)) state_in = ST_PJ_WAIT;
         ST_PJ_WAIT: if (!rdv_ff && !prv_ff) state_in = ST_M_GO;
         ST_FIN:     state_in = root_start ? ST_ROOT : ST_OUT;
         ST_ROOT:    if (root_done) state_in = ST_OUT;
         ST_OUT:     if (rsp_load) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= ACTIVE_SIZE_RST;
         spacing_ff   <= GRID_SPACING_RST;
         relcfg_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rdv_ff       <= 1'b0;
         prv_ff       <= 1'b0;
      end else begin
         state_ff <= state_in;
         rdv_ff   <= state_ff == ST_PJ;
         prv_ff   <= rdv_ff;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ACTIVE_SIZE:   active_ff  <= csr_wdata[6:0];
               CSR_GRID_SPACING:  spacing_ff <= csr_wdata;
               CSR_RELATIVE_MODE: relcfg_ff  <= csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      p_rr_ff <= 65'(op_ar) * 65'(op_br);
      p_ii_ff <= 65'(op_ai) * 65'(op_bi);
      p_ri_ff <= 65'(op_ar) * 65'(op_bi);
      p_ir_ff <= 65'(op_ai) * 65'(op_br);
      if (prv_ff) begin
         are_ff <= are_ff + 64'(p_rr_ff >>> 16) + 64'(p_ii_ff >>> 16);
         aim_ff <= aim_ff + 64'(p_ri_ff >>> 16) - 64'(p_ir_ff >>> 16);
      end else if (state_ff == ST_CXS) begin
         are_ff <= '0;
         aim_ff <= '0;
      end
      if (rsp_load) begin
         rsp_data_ff.theta        <= res_theta_ff;
         rsp_data_ff.was_relative <= rel_ff;
         rsp_data_ff.saturated    <= res_sat_ff;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && is_eval) begin
               t_ff   <= req_data.time_req;
               n_ff   <= n_eval;
               dx_ff  <= (spacing_ff == '0) ? DX_ONE : spacing_ff;
               rel_ff <= relcfg_ff;
               num_ff <= '0;
               den_ff <= '0;
               k_ff   <= '0;
               j_ff   <= '0;
            end
         end
         ST_K_EMUL: begin
            a_ff   <= 64'(signed'(energy_q)) * 64'(t_ff);
            c0r_ff <= signed'(coeff_q[63:32]);
            c0i_ff <= signed'(coeff_q[31:0]);
            job_ff <= JOB_PHASE;
         end
         ST_M_WAIT: begin
            if (mul_done) begin
               job_ff <= job_type'(job_ff + 3'd1);
               case (job_ff)
                  JOB_SC_RE:  dre_ff <= clamp(cre_ff - sc_val);
                  JOB_SC_IM:  dim_ff <= clamp(cim_ff - sc_val);
                  JOB_SQ_DRE: num_ff <= sat_add(num_ff, mul_p);
                  JOB_SQ_DIM: num_ff <= sat_add(num_ff, mul_p);
                  JOB_SQ_CRE: den_ff <= sat_add(den_ff, mul_p);
                  JOB_SQ_CIM: begin
                     den_ff <= sat_add(den_ff, mul_p);
                     k_ff   <= k_ff + CW'(1);
                  end
                  default: ;
               endcase
            end
         end
         ST_CORD: begin
            if (cordic_done) begin
               cos_ff <= cos_q;
               sin_ff <= sin_q;
            end
         end
         ST_CXS: begin
            // products here are c0r*c, c0i*s, c0r*s, c0i*c
            cre_ff   <= 64'((66'(p_rr_ff) + 66'(p_ii_ff)) >>> 30);
            cim_ff   <= 64'((66'(p_ir_ff) - 66'(p_ri_ff)) >>> 30);
            j_ff     <= '0;
            vaddr_ff <= AW'(k_ff);
         end
         ST_PJ: begin
            j_ff     <= j_ff + CW'(1);
            vaddr_ff <= vaddr_ff + AW'(MAX_SIZE);
         end
         ST_PJ_WAIT: job_ff <= JOB_SC_RE;
         ST_FIN: begin
            if (!rel_ff) begin
               res_sat_ff   <= num_ff[127:64] != '0;
               res_theta_ff <= (num_ff[127:64] != '0) ? '1 : num_ff[63:0];
            end else begin
               res_sat_ff   <= rel_sat;
               res_theta_ff <= '1;
            end
         end
         ST_ROOT: if (root_done) res_theta_ff <= root_q;
         default: ;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> rtl/spe_checker.sv
module spe_port_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input spe_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input spe_pkg::rsp_type rsp_data
);
   import spe_pkg::*;

   // once an evaluate beat is taken, req_ready must be low right after it
   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.command == CMD_EVAL |=> !req_ready)
      else $error("req_ready high right after evaluate beat");

   a_load_quiet: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.command != CMD_EVAL && !rsp_valid |=> !rsp_valid)
      else $error("load beat produced a result");

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared without an evaluation in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled rsp beat changed");

endmodule

bind spectral_projection_error_unit spe_port_checker u_spe_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
